// File: sv/first_fit_heap_allocator_core_assert.svh
// Assertion macros shared by the heap allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define FFHA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FFHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/ffha_pkg.sv
`default_nettype none
package ffha_pkg;

   localparam int HEAP_BYTES = 65536;
   localparam int HEAP_TOP   = (HEAP_BYTES / 16) * 16;
   localparam int DEPTH      = HEAP_TOP / 16;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int STEP_W     = IDX_W + 1;
   localparam int SIZE_W     = 17;
   localparam int NEXT_W     = ((SIZE_W - 4) > IDX_W ? (SIZE_W - 4) : IDX_W) + 1;
   localparam int TAKEN_W    = SIZE_W + 1;
   localparam int ADDR_W     = 16;
   localparam int STATUS_W   = 2;

   localparam logic [SIZE_W-1:0] INIT_BLK = SIZE_W'(HEAP_TOP - 16);
   localparam logic [SIZE_W-1:0] INIT_PAY = SIZE_W'(HEAP_TOP - 24);
   localparam logic [SIZE_W-1:0] END_MARK = SIZE_W'(1);

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

   typedef struct packed {
      logic [SIZE_W-1:0] blk;
      logic [SIZE_W-1:0] pay;
   } word_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      word_type         data;
   } wr_type;

endpackage
`default_nettype wire

// File: sv/first_fit_heap_allocator_core.sv
// Channel   Ports                                                       Beat taken when
// request   start, busy, req_kind, req_request_size, req_free_address   start && !busy
// response  rsp_strobe, rsp_status, rsp_payload_address                 rsp_strobe (one cycle)
//
// Reset starts a sweep that writes every entry of the header memory; busy stays high throughout.
// A request visits the headers in order, as the single memory read port fetches one
// header a cycle; a hit on allocate adds a write state, and a free adds the states
// write, read next header, merge forward and merge back (read and merge skipped at heap end).
// The response beat comes in the first cycle with busy low; the receiver cannot stall.
`default_nettype none
`include "first_fit_heap_allocator_core_assert.svh"
module first_fit_heap_allocator_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          req_kind,
   input  wire logic [ffha_pkg::SIZE_W-1:0]   req_request_size,
   input  wire logic [ffha_pkg::ADDR_W-1:0]   req_free_address,
   output logic                               busy,
   output logic                               rsp_strobe,
   output logic [ffha_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ffha_pkg::ADDR_W-1:0]        rsp_payload_address
);
   import ffha_pkg::*;

   typedef enum logic [7:0] {
      ST_CLEAR     = 8'b0000_0001,
      ST_IDLE      = 8'b0000_0010,
      ST_WALK      = 8'b0000_0100,
      ST_ALLOC_WR  = 8'b0000_1000,
      ST_FREE_WR   = 8'b0001_0000,
      ST_FREE_RD   = 8'b0010_0000,
      ST_FREE_MRG  = 8'b0100_0000,
      ST_FREE_PRV  = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic                 kind_ff, kind_in;
   logic [SIZE_W-1:0]    want_ff, want_in;
   logic [TAKEN_W-1:0]   want_pad_ff, want_pad_in;
   logic [TAKEN_W-1:0]   taken_ff, taken_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [IDX_W-1:0]     prev_ff, prev_in;
   logic [SIZE_W-1:0]    prev_blk_ff, prev_blk_in;
   logic                 has_prev_ff, has_prev_in;
   logic [SIZE_W-1:0]    hit_blk_ff, hit_blk_in;
   logic [SIZE_W-1:0]    hit_pay_ff, hit_pay_in;
   logic [SIZE_W-1:0]    sz_ff, sz_in;
   logic [NEXT_W-1:0]    nxt_ff, nxt_in;
   logic [SIZE_W-1:0]    cur_blk_ff, cur_blk_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;

   wr_type               wr;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   word_type             rd_word;
   logic                 store_ready;

   logic [3:0]           pad;
   logic                 is_free;
   logic                 is_end;
   logic                 fits;
   logic                 split;
   logic [SIZE_W-1:0]    diff;
   logic                 match;
   logic [NEXT_W-1:0]    next_sum;
   logic [TAKEN_W-4:0]   rest_sum;
   logic [ADDR_W-1:0]    hdr_addr;
   logic [SIZE_W-1:0]    merged;

   ffha_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word),
      .ready   (store_ready)
   );

   always_comb begin
      pad      = 4'd8 - req_request_size[3:0];
      is_free  = (rd_word.blk[3:0] == 4'd0);
      is_end   = (rd_word.blk[SIZE_W-1:4] == '0);
      fits     = is_free && (rd_word.pay >= want_ff);
      diff     = rd_word.pay - want_ff;
      split    = (diff[SIZE_W-1:4] != '0);
      hdr_addr = ADDR_W'({idx_ff, 4'b1000});
      match    = (hdr_addr == addr_ff) && !is_free;
      next_sum = NEXT_W'(idx_ff) + NEXT_W'(rd_word.blk[SIZE_W-1:4]);
      rest_sum = (TAKEN_W - 3)'(idx_ff) + (TAKEN_W - 3)'(taken_ff[TAKEN_W-1:4]);
      merged   = sz_ff + rd_word.blk;
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      want_in       = want_ff;
      want_pad_in   = want_pad_ff;
      taken_in      = taken_ff;
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      prev_in       = prev_ff;
      prev_blk_in   = prev_blk_ff;
      has_prev_in   = has_prev_ff;
      hit_blk_in    = hit_blk_ff;
      hit_pay_in    = hit_pay_ff;
      sz_in         = sz_ff;
      nxt_in        = nxt_ff;
      cur_blk_in    = cur_blk_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      wr            = '0;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            if (store_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               kind_in     = req_kind;
               want_in     = req_request_size;
               want_pad_in = TAKEN_W'(req_request_size) + TAKEN_W'(pad);
               taken_in    = TAKEN_W'(req_request_size) + TAKEN_W'(pad) + TAKEN_W'(8);
               addr_in     = req_free_address;
               idx_in      = '0;
               step_in     = '0;
               has_prev_in = 1'b0;
               rd_en       = 1'b1;
               rd_addr     = '0;
               state_in    = ST_WALK;
            end
         end
         ST_WALK: begin
            priority if (kind_ff == KIND_ALLOC && fits) begin
               if (split) begin
                  wr.en       = 1'b1;
                  wr.addr     = rest_sum[IDX_W-1:0];
                  wr.data.blk = SIZE_W'(TAKEN_W'(rd_word.pay) - want_pad_ff);
                  wr.data.pay = SIZE_W'(TAKEN_W'(rd_word.pay) - taken_ff);
                  hit_blk_in  = SIZE_W'(taken_ff + TAKEN_W'(1));
               end else begin
                  hit_blk_in  = rd_word.pay + SIZE_W'(9);
               end
               hit_pay_in = rd_word.pay;
               state_in   = ST_ALLOC_WR;
            end else if (kind_ff == KIND_FREE && match) begin
               sz_in    = rd_word.blk - SIZE_W'(1);
               state_in = ST_FREE_WR;
            end else if (is_end || step_ff == STEP_W'(DEPTH - 1)
                         || next_sum >= NEXT_W'(DEPTH)) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = (kind_ff == KIND_ALLOC) ? STATUS_NO_FIT : STATUS_BAD_FREE;
               rsp_addr_in   = '0;
               state_in      = ST_IDLE;
            end else begin
               prev_in     = idx_ff;
               prev_blk_in = rd_word.blk;
               has_prev_in = 1'b1;
               idx_in      = next_sum[IDX_W-1:0];
               step_in     = step_ff + 1'b1;
               rd_en       = 1'b1;
               rd_addr     = next_sum[IDX_W-1:0];
            end
         end
         ST_ALLOC_WR: begin
            wr.en         = 1'b1;
            wr.addr       = idx_ff;
            wr.data.blk   = hit_blk_ff;
            wr.data.pay   = hit_pay_ff;
            rsp_strobe_in = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_addr_in   = hdr_addr;
            state_in      = ST_IDLE;
         end
         ST_FREE_WR: begin
            wr.en       = 1'b1;
            wr.addr     = idx_ff;
            wr.data.blk = sz_ff;
            wr.data.pay = sz_ff - SIZE_W'(8);
            cur_blk_in  = sz_ff;
            nxt_in      = NEXT_W'(idx_ff) + NEXT_W'(sz_ff[SIZE_W-1:4]);
            if (nxt_in >= NEXT_W'(DEPTH)) begin
               state_in = ST_FREE_PRV;
            end else begin
               state_in = ST_FREE_RD;
            end
         end
         ST_FREE_RD: begin
            rd_en    = 1'b1;
            rd_addr  = nxt_ff[IDX_W-1:0];
            state_in = ST_FREE_MRG;
         end
         ST_FREE_MRG: begin
            if (is_free) begin
               wr.en       = 1'b1;
               wr.addr     = idx_ff;
               wr.data.blk = merged;
               wr.data.pay = merged - SIZE_W'(8);
               cur_blk_in  = merged;
            end
            state_in = ST_FREE_PRV;
         end
         ST_FREE_PRV: begin
            if (has_prev_ff && prev_blk_ff[3:0] == 4'd0) begin
               wr.en       = 1'b1;
               wr.addr     = prev_ff;
               wr.data.blk = prev_blk_ff + cur_blk_ff;
               wr.data.pay = prev_blk_ff + cur_blk_ff - SIZE_W'(8);
            end
            rsp_strobe_in = 1'b1;
            rsp_status_in = STATUS_OK;
            rsp_addr_in   = '0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      want_ff       <= want_in;
      want_pad_ff   <= want_pad_in;
      taken_ff      <= taken_in;
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      step_ff       <= step_in;
      prev_ff       <= prev_in;
      prev_blk_ff   <= prev_blk_in;
      has_prev_ff   <= has_prev_in;
      hit_blk_ff    <= hit_blk_in;
      hit_pay_ff    <= hit_pay_in;
      sz_ff         <= sz_in;
      nxt_ff        <= nxt_in;
      cur_blk_ff    <= cur_blk_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_payload_address = rsp_addr_ff;

   `FFHA_ASSERT_NOW(a_beat_after_work, clock, reset, rsp_strobe, $past(busy), "response without work")
   `FFHA_ASSERT_NEXT(a_busy_after_start, clock, reset, start && !busy, busy, "request not taken up")
   `FFHA_ASSERT_NOW(a_error_zero_addr, clock, reset, rsp_strobe && rsp_status != STATUS_OK, rsp_payload_address == '0, "error with address")

endmodule
`default_nettype wire

// File: sv/ffha_store.sv
`default_nettype none
`include "first_fit_heap_allocator_core_assert.svh"
module ffha_store (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ffha_pkg::wr_type          wr,
   input  wire logic                      rd_en,
   input  wire logic [ffha_pkg::IDX_W-1:0] rd_addr,
   output ffha_pkg::word_type             rd_data,
   output logic                           ready
);
   import ffha_pkg::*;

   word_type         mem [DEPTH];
   word_type         rd_data_ff;
   logic             clearing_ff, clearing_in;
   logic [IDX_W-1:0] clear_idx_ff, clear_idx_in;
   word_type         clear_word;

   always_comb begin
      clear_word = '0;
      if (clear_idx_ff == '0) begin
         clear_word.blk = INIT_BLK;
         clear_word.pay = INIT_PAY;
      end else if (clear_idx_ff == IDX_W'(DEPTH - 1)) begin
         clear_word.blk = END_MARK;
      end
      clear_idx_in = clear_idx_ff + 1'b1;
      clearing_in  = clearing_ff && (clear_idx_ff != IDX_W'(DEPTH - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_idx_ff <= '0;
      end else if (clearing_ff) begin
         clearing_ff  <= clearing_in;
         clear_idx_ff <= clear_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clear_idx_ff] <= clear_word;
      end else if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clearing_ff;

   `FFHA_ASSERT_NOW(a_no_write_in_sweep, clock, reset, !ready, !wr.en, "write during sweep")
   `FFHA_ASSERT_NOW(a_no_rw_collision, clock, reset, wr.en && rd_en, wr.addr != rd_addr, "read of entry under write")
   `FFHA_ASSERT_NEXT(a_ready_holds, clock, reset, ready, ready, "sweep restarted without reset")

endmodule
`default_nettype wire
